/* hw/rtl/fsmap_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the frame segment mapper.
// No dependencies; imported by fsmap_table, fsmap_core and the top level.
package fsmap_pkg;

    localparam int SEGMENTS_DEFAULT = 16;
    // Entries at or above this index cannot be addressed by the 4-bit segment index.
    localparam int MAX_TABLE = 16;
    localparam int COUNT_W = 5;
    localparam int SIDX_W = 4;
    localparam int FRAME_W = 32;
    localparam int SRC_W = 8;
    // Cumulative length of up to 16 entries of 32 bits.
    localparam int BASE_W = FRAME_W + COUNT_W;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_FETCH   = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_INVERSE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [SRC_W-1:0]   source;
        logic [FRAME_W-1:0] start;
        logic [FRAME_W-1:0] length;
    } entry_t;

    // Field order matches m_tdata from the top bit down.
    typedef struct packed {
        logic               sequential;
        logic [FRAME_W-1:0] frame_out;
        logic [SRC_W-1:0]   source_out;
        logic [FRAME_W-1:0] relative_out;
        logic [SIDX_W-1:0]  segment_out;
        logic               ok;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

endpackage

/* hw/rtl/fsmap_table.sv */
`timescale 1ns / 1ps
// Segment table storage: one write port, one read port with registered data.
// Depends on fsmap_pkg for the entry type.
module fsmap_table
    import fsmap_pkg::*;
#(
    parameter int DEPTH = MAX_TABLE,
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/fsmap_core.sv */
`timescale 1ns / 1ps
// Sequencer and shared walk adder: table writes, lookups, inverse mapping
// and fetch tracking. Depends on fsmap_pkg and fsmap_table.
module fsmap_core
    import fsmap_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mode_t              mode,
    input  logic [SIDX_W-1:0]  segment_index,
    input  logic [FRAME_W-1:0] frame_number,
    input  logic [FRAME_W-1:0] relative_frame,
    input  entry_t             entry,
    input  logic [COUNT_W-1:0] segment_count,
    input  logic               take,
    output core_status_t       status,
    output result_t            result
);

    localparam int TBL_DEPTH = (SEGMENTS < MAX_TABLE) ? SEGMENTS : MAX_TABLE;
    localparam int IDX_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] TBL_DEPTH_C = COUNT_W'(TBL_DEPTH);
    localparam logic [8:0] SEGMENTS_C = 9'(SEGMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC,
        ST_TRACK,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [SIDX_W-1:0]  sidx_reg, sidx_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [FRAME_W-1:0] relin_reg, relin_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [FRAME_W-1:0] start_reg, start_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [FRAME_W-1:0] rel_reg, rel_next;
    logic [SIDX_W-1:0]  last_seg_reg, last_seg_next;
    logic [FRAME_W-1:0] last_rel_reg, last_rel_next;
    result_t            result_reg, result_next;

    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;
    logic [COUNT_W-1:0] n_eff;
    logic [COUNT_W-1:0] idx_inc;
    logic [BASE_W-1:0]  walk_sum;
    logic               walk_hit;

    assign n_eff = (segment_count > TBL_DEPTH_C) ? TBL_DEPTH_C : segment_count;
    assign idx_inc = idx_reg + COUNT_W'(1);
    assign wr_en = start && (state_reg == ST_IDLE) && (mode == MODE_WRITE)
                   && ({5'd0, segment_index} < SEGMENTS_C);
    // Prefetch the next entry while the current one is checked.
    assign rd_addr = (state_reg == ST_CHECK) ? idx_inc[IDX_W-1:0] : '0;

    fsmap_table #(
        .DEPTH (TBL_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (segment_index[IDX_W-1:0]),
        .wdata (entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Shared walk unit: running base plus current length.
    assign walk_sum = base_reg + {{COUNT_W{1'b0}}, rd_data.length};
    assign walk_hit = (mode_reg == MODE_INVERSE)
                      ? (idx_reg == {1'b0, sidx_reg})
                      : ({{COUNT_W{1'b0}}, frame_reg} < walk_sum);

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        sidx_next     = sidx_reg;
        frame_next    = frame_reg;
        relin_next    = relin_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        base_next     = base_reg;
        start_next    = start_reg;
        src_next      = src_reg;
        rel_next      = rel_reg;
        last_seg_next = last_seg_reg;
        last_rel_next = last_rel_reg;
        result_next   = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    sidx_next   = segment_index;
                    frame_next  = frame_number;
                    relin_next  = relative_frame;
                    n_next      = n_eff;
                    idx_next    = '0;
                    base_next   = '0;
                    result_next = '0;
                    case (mode)
                        MODE_WRITE:
                        begin
                            result_next.ok = wr_en;
                            state_next     = ST_DONE;
                        end
                        MODE_INVERSE:
                        begin
                            state_next = ({1'b0, segment_index} < n_eff) ? ST_CHECK : ST_DONE;
                        end
                        default:
                        begin
                            state_next = (n_eff != '0) ? ST_CHECK : ST_DONE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (walk_hit)
                begin
                    start_next = rd_data.start;
                    src_next   = rd_data.source;
                    state_next = ST_CALC;
                end
                else
                begin
                    base_next = walk_sum;
                    idx_next  = idx_inc;
                    if (idx_inc == n_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CALC:
            begin
                result_next.ok = 1'b1;
                if (mode_reg == MODE_INVERSE)
                begin
                    result_next.frame_out = base_reg[FRAME_W-1:0] + relin_reg - start_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    rel_next = start_reg + frame_reg - base_reg[FRAME_W-1:0];
                    result_next.segment_out  = idx_reg[SIDX_W-1:0];
                    result_next.relative_out = rel_next;
                    result_next.source_out   = src_reg;
                    state_next = (mode_reg == MODE_FETCH) ? ST_TRACK : ST_DONE;
                end
            end
            ST_TRACK:
            begin
                result_next.sequential = (idx_reg[SIDX_W-1:0] == last_seg_reg)
                                         && ((last_rel_reg + FRAME_W'(1)) == rel_reg);
                last_seg_next = idx_reg[SIDX_W-1:0];
                last_rel_next = rel_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            last_seg_reg <= '0;
            last_rel_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            last_seg_reg <= last_seg_next;
            last_rel_reg <= last_rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        sidx_reg   <= sidx_next;
        frame_reg  <= frame_next;
        relin_reg  <= relin_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        base_reg   <= base_next;
        start_reg  <= start_next;
        src_reg    <= src_next;
        rel_reg    <= rel_next;
        result_reg <= result_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign result      = result_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("request started while core busy");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> idx_reg < n_reg)
        else $error("table walk past effective count");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !take) |=> state_reg == ST_DONE && $stable(result_reg))
        else $error("pending result changed before taken");

    a_track_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRACK |=> last_rel_reg == $past(rel_reg))
        else $error("fetch tracking not updated");

    a_track_only_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_TRACK) |=> $stable(last_rel_reg) && $stable(last_seg_reg))
        else $error("tracking changed outside a fetch");

endmodule

/* hw/rtl/frame_segment_mapper_unit.sv */
`timescale 1ns / 1ps
// Frame segment mapper top level: stream ports, count register, result register.
// Depends on fsmap_pkg and fsmap_core.
//
// Maps timeline frames onto a table of up to 16 edit segments (length, source
// start frame, source index). One request is worked at a time: s_tready is low
// while it runs. A table write goes from idle straight to done; a lookup or
// inverse mapping walks the table one entry per cycle through a single shared
// adder and compare, and a fetch lookup also passes a tracking update step.
// The result sits in an output register, so the next request is accepted
// while it waits. The user must write segment_count through cfg_* only while
// no request is in flight; the block itself does not enforce it.
module frame_segment_mapper_unit
    import fsmap_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,   // segment_count
    input  logic               s_tvalid,
    output logic               s_tready,
    // s_tdata: segment_index[3:0], frame_number[35:4], relative_frame[67:36],
    // entry_length[99:68], entry_start[131:100], entry_source[139:132], zero pad
    input  logic [143:0]       s_tdata,
    input  logic [1:0]         s_tuser,    // mode
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata: ok[0], segment_out[4:1], relative_out[36:5], source_out[44:37],
    // frame_out[76:45], sequential[77], zero pad
    output logic [79:0]        m_tdata
);

    logic [COUNT_W-1:0] count_reg;
    logic               m_tvalid_reg;
    result_t            m_result_reg;
    core_status_t       core_status;
    result_t            core_result;
    entry_t             in_entry;
    logic               in_accept;
    logic               out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = core_status.idle;
    assign in_accept = s_tvalid && s_tready;
    // Result register frees itself when the downstream takes it.
    assign out_load  = core_status.done && (!m_tvalid_reg || m_tready);

    assign in_entry.length = s_tdata[99:68];
    assign in_entry.start  = s_tdata[131:100];
    assign in_entry.source = s_tdata[139:132];

    fsmap_core #(
        .SEGMENTS (SEGMENTS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (in_accept),
        .mode           (mode_t'(s_tuser)),
        .segment_index  (s_tdata[3:0]),
        .frame_number   (s_tdata[35:4]),
        .relative_frame (s_tdata[67:36]),
        .entry          (in_entry),
        .segment_count  (count_reg),
        .take           (out_load),
        .status         (core_status),
        .result         (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_result_reg <= core_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_result_reg};

endmodule

/* bench/segment_map_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for the frame segment mapper: watches the config, request and result
// channels, keeps its own segment table and fetch tracking, and compares results.
// Depends on fsmap_pkg.
module segment_map_scoreboard
    import fsmap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [143:0]       s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [79:0]        m_tdata,
    output int                 fail_count,
    output int                 in_flight
);

    logic [FRAME_W-1:0] len_tab [MAX_TABLE];
    logic [FRAME_W-1:0] start_tab [MAX_TABLE];
    logic [SRC_W-1:0]   src_tab [MAX_TABLE];
    logic [SIDX_W-1:0]  prev_seg;
    logic [FRAME_W-1:0] prev_rel;
    logic [COUNT_W-1:0] seg_count;
    result_t            mapped_q [$];
    int                 mismatches = 0;
    int                 waiting = 0;

    // expectations never delivered count as failures too
    assign fail_count = mismatches + waiting;

    function automatic result_t map_request(input mode_t mode, input logic [143:0] req);
        logic [SIDX_W-1:0]  sidx;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] rel_in;
        logic [FRAME_W-1:0] rel;
        logic [FRAME_W-1:0] sum;
        logic [BASE_W-1:0]  base;
        result_t            res;
        int                 limit;
        bit                 hit;
        sidx   = req[3:0];
        frame  = req[35:4];
        rel_in = req[67:36];
        res    = '0;
        base   = '0;
        sum    = '0;
        hit    = 1'b0;
        limit  = (seg_count > MAX_TABLE) ? MAX_TABLE : int'(seg_count);
        case (mode)
            MODE_WRITE:
            begin
                len_tab[sidx]   = req[99:68];
                start_tab[sidx] = req[131:100];
                src_tab[sidx]   = req[139:132];
                res.ok = 1'b1;
            end
            MODE_FETCH, MODE_LOOKUP:
            begin
                // walk without wrap: the base is wide enough for 16 full entries
                for (int i = 0; i < limit; i++)
                begin
                    if (!hit && frame >= base && frame < base + len_tab[i])
                    begin
                        hit = 1'b1;
                        rel = start_tab[i] + frame - base[FRAME_W-1:0];
                        res.ok = 1'b1;
                        res.segment_out = SIDX_W'(i);
                        res.relative_out = rel;
                        res.source_out = src_tab[i];
                        if (mode == MODE_FETCH)
                        begin
                            res.sequential = (SIDX_W'(i) == prev_seg) &&
                                             (prev_rel + 32'd1 == rel);
                            prev_seg = SIDX_W'(i);
                            prev_rel = rel;
                        end
                    end
                    base = base + len_tab[i];
                end
            end
            default:
            begin
                if (sidx < limit)
                begin
                    for (int i = 0; i < sidx; i++)
                        sum = sum + len_tab[i];
                    res.frame_out = sum + rel_in - start_tab[sidx];
                    res.ok = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        want = mapped_q.pop_front();
        if (got.ok !== want.ok)
        begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            mismatches++;
        end
        if (got.segment_out !== want.segment_out)
        begin
            $error("segment_out: expected %0d, got %0d", want.segment_out, got.segment_out);
            mismatches++;
        end
        if (got.relative_out !== want.relative_out)
        begin
            $error("relative_out: expected %h, got %h", want.relative_out, got.relative_out);
            mismatches++;
        end
        if (got.source_out !== want.source_out)
        begin
            $error("source_out: expected %h, got %h", want.source_out, got.source_out);
            mismatches++;
        end
        if (got.frame_out !== want.frame_out)
        begin
            $error("frame_out: expected %h, got %h", want.frame_out, got.frame_out);
            mismatches++;
        end
        if (got.sequential !== want.sequential)
        begin
            $error("sequential: expected %0d, got %0d", want.sequential, got.sequential);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seg  = '0;
            prev_rel  = '0;
            seg_count = '0;
            mapped_q.delete();
            waiting   = 0;
        end
        else
        begin
            // a result never leaves in the cycle its request is taken, so results go first
            if (m_tvalid && m_tready)
            begin
                if (mapped_q.size() == 0)
                begin
                    $error("result with no request waiting: %h", m_tdata);
                    mismatches++;
                end
                else
                    check_result(result_t'(m_tdata[77:0]));
            end
            if (cfg_valid && cfg_ready)
                seg_count = cfg_data;
            if (s_tvalid && s_tready)
                mapped_q.push_back(map_request(mode_t'(s_tuser), s_tdata));
            waiting = mapped_q.size();
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_flight <= 0;
        else
            in_flight <= in_flight + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
    end

endmodule

/* bench/frame_segment_mapper_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for frame_segment_mapper_unit: clock, reset, request and count
// stimulus, random output backpressure. Depends on fsmap_pkg, the DUT and segment_map_scoreboard.
module frame_segment_mapper_unit_tb;
    import fsmap_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [143:0]       s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [79:0]        m_tdata;
    int                 fail_count;
    int                 in_flight;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_wanted = 1'b0;
    bit                 hold_served = 1'b0;

    // stimulus-side copy of the table, only used to aim requests at live segments
    logic [31:0]        plan_len [MAX_TABLE];
    logic [31:0]        plan_start [MAX_TABLE];
    int                 plan_count = 0;
    logic [31:0]        cursor = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    frame_segment_mapper_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    segment_map_scoreboard u_score (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_wanted && !hold_served)
            begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input mode_t mode, input logic [3:0] sidx,
                                input logic [31:0] frame, input logic [31:0] rel,
                                input logic [31:0] len, input logic [31:0] start,
                                input logic [7:0] src);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, src, start, len, rel, frame, sidx};
        do @(posedge clk); while (!s_tready);
        if (mode == MODE_WRITE)
        begin
            plan_len[sidx]   = len;
            plan_start[sidx] = start;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_count = (value > MAX_TABLE) ? MAX_TABLE : value;
    endtask

    // mostly frames inside a live segment, some at the table end, some anywhere
    function automatic logic [31:0] aim_frame();
        logic [36:0] total;
        logic [36:0] base;
        int          k;
        total = '0;
        base  = '0;
        for (int i = 0; i < plan_count; i++)
            total = total + plan_len[i];
        k = $urandom_range(0, 9);
        if (total == 0 || k == 0)
            return $urandom;
        if (k == 1)
            return total[31:0];
        if (k == 2)
            return total[31:0] - 32'd1;
        k = $urandom_range(0, plan_count - 1);
        for (int i = 0; i < k; i++)
            base = base + plan_len[i];
        if (plan_len[k] == 0)
            return base[31:0];
        return base[31:0] + ($urandom % plan_len[k]);
    endfunction

    task automatic run_phase(input int count_value, input int items, input bit with_hold);
        int          pick;
        logic [3:0]  sidx;
        logic [31:0] frame;
        logic [31:0] len;
        set_count(count_value);
        for (int n = 0; n < items; n++)
        begin
            if (with_hold && n == items / 3)
                hold_wanted = 1'b1;
            pick = $urandom_range(0, 99);
            sidx = 4'($urandom_range(0, 15));
            if (pick < 12)
            begin
                case ($urandom_range(0, 9))
                    0:       len = '0;
                    1:       len = 32'd1;
                    2:       len = $urandom;
                    default: len = 32'($urandom_range(0, 40));
                endcase
                send_request(MODE_WRITE, sidx, $urandom, $urandom, len, $urandom,
                             8'($urandom));
            end
            else if (pick < 55)
            begin
                // half the fetches step one frame on, to build sequential runs
                frame = ($urandom_range(0, 1) == 0) ? cursor + 32'd1 : aim_frame();
                cursor = frame;
                send_request(MODE_FETCH, sidx, frame, $urandom, $urandom, $urandom,
                             8'($urandom));
            end
            else if (pick < 75)
                send_request(MODE_LOOKUP, sidx, aim_frame(), $urandom, $urandom, $urandom,
                             8'($urandom));
            else
            begin
                frame = ($urandom_range(0, 1) == 0) ?
                        plan_start[sidx] + 32'($urandom_range(0, 40)) : $urandom;
                send_request(MODE_INVERSE, sidx, $urandom, frame, $urandom, $urandom,
                             8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_WRITE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // fill every entry before anything reads the table
        set_count(16);
        for (int i = 0; i < MAX_TABLE; i++)
            send_request(MODE_WRITE, 4'(i), $urandom, $urandom,
                         (i == 0) ? 32'd0 : (i == 15) ? 32'hFFFF_FFFF : 32'(i),
                         (i == 0) ? 32'd0 : (i == 15) ? 32'hFFFF_FFFF : $urandom,
                         i[0] ? 8'hFF : 8'h00);
        // zero-length entry 0 is skipped; plain lookup must not disturb tracking
        send_request(MODE_FETCH, 4'd0, 32'd1, '0, '0, '0, '0);
        send_request(MODE_LOOKUP, 4'd0, 32'd0, '0, '0, '0, '0);
        send_request(MODE_FETCH, 4'd0, 32'd2, '0, '0, '0, '0);
        // past 2^32 only through the last entry: sum must not wrap, relative wraps
        send_request(MODE_FETCH, 4'd0, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_request(MODE_LOOKUP, 4'd15, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_request(MODE_INVERSE, 4'd15, '0, 32'hFFFF_FFFF, '0, '0, '0);
        send_request(MODE_INVERSE, 4'd0, '0, 32'd0, '0, '0, '0);
        send_request(MODE_FETCH, 4'd0, 32'd0, '0, '0, '0, '0);
        // short table: a failed fetch keeps the previous tracking
        set_count(3);
        send_request(MODE_FETCH, 4'd0, 32'd1, '0, '0, '0, '0);
        send_request(MODE_FETCH, 4'd0, 32'd3, '0, '0, '0, '0);
        send_request(MODE_FETCH, 4'd0, 32'd2, '0, '0, '0, '0);
        send_request(MODE_INVERSE, 4'd3, '0, 32'd5, '0, '0, '0);

        run_phase(31, 260, 1'b0);
        run_phase(1, 150, 1'b0);
        run_phase(0, 60, 1'b0);
        run_phase($urandom_range(2, 15), 260, 1'b1);
        run_phase(17, 220, 1'b0);
        run_phase($urandom_range(1, 16), 250, 1'b0);
        calm = 1'b1;
        run_phase(16, 250, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
